[hw/rtl/egsc_pkg.sv]
// egsc_pkg: shared constants, register codes and status types of the grip servo controller
// no dependencies; imported by the interfaces, the serial units and the top level

package egsc_pkg;

  // default sample width and fixed field widths
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int CFG_IDX_W        = 4;
  localparam int CFG_DATA_W       = 16;
  localparam int DEAD_W           = 15;
  localparam int HOLD_W           = 13;
  localparam int ANGLE_W          = 16;
  localparam int GRIP_PCT_W       = 7;
  localparam int FILT_W           = 16;
  localparam int GRIP_W           = 23;

  // serial multiplier: multiplier operand width and step counter
  localparam int MR_W      = 16;
  localparam int MUL_CNT_W = $clog2(MR_W);

  // serial divider: remainder/quotient register width, dividend width, step counter
  localparam int DIV_W     = 23;
  localparam int DVD_W     = 39;
  localparam int DIV_CNT_W = 5;

  localparam logic [DIV_CNT_W-1:0] TGT_DIV_STEPS = 5'd23;
  localparam logic [DIV_CNT_W-1:0] ANG_DIV_STEPS = 5'd16;

  // fixed-point constants
  localparam logic [GRIP_W-1:0] PCT_FULL    = 23'd6553600;  // 100.0 in Q7.16
  localparam logic [15:0]       ROUND_Q15   = 16'd16384;    // 0.5 before a >> 15
  localparam logic [DVD_W-1:0]  ANG_ROUND   = 39'd3276800;  // half of 100.0 in Q7.16
  localparam logic [GRIP_W:0]   PCT_HALF    = 24'd32768;    // 0.5 percent in Q7.16
  localparam logic [15:0]       SPAN_FLOOR  = 16'd256;      // 1.0 in Q8.8

  // register reset values
  localparam logic [15:0]       ENV_OPEN_RST     = 16'd2048;
  localparam logic [15:0]       ENV_CLOSE_RST    = 16'd15360;
  localparam logic [15:0]       ENV_ALPHA_RST    = 16'd6554;
  localparam logic [15:0]       GRIP_ALPHA_RST   = 16'd9830;
  localparam logic [DEAD_W-1:0] DEADBAND_PCT_RST = 15'd1536;
  localparam logic [HOLD_W-1:0] HOLD_PCT_RST     = 13'd256;
  localparam logic [15:0]       OPEN_ANGLE_RST   = 16'd0;
  localparam logic [15:0]       CLOSE_ANGLE_RST  = 16'd23040;

  // register index codes
  localparam logic [CFG_IDX_W-1:0] REG_ENV_OPEN     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENV_CLOSE    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENV_ALPHA    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRIP_ALPHA   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND_PCT = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_PCT     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_ANGLE   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_ANGLE  = 4'd7;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } egsc_unit_sts_t;

endpackage

[hw/rtl/egsc_in_if.sv]
// egsc_in_if: input channel carrying one envelope sample per beat
// depends on egsc_pkg

interface egsc_in_if import egsc_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] envelope_sample;

  modport source (output valid, output envelope_sample, input ready);
  modport sink   (input valid, input envelope_sample, output ready);
endinterface

[hw/rtl/egsc_out_if.sv]
// egsc_out_if: result channel carrying servo angle, grip percent and filtered level
// depends on egsc_pkg

interface egsc_out_if import egsc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [ANGLE_W-1:0]    servo_angle;
  logic [GRIP_PCT_W-1:0] grip_pct;
  logic [FILT_W-1:0]     filtered_level;

  modport source (output valid, output servo_angle, output grip_pct,
                  output filtered_level, input ready);
  modport sink   (input valid, input servo_angle, input grip_pct,
                  input filtered_level, output ready);
endinterface

[hw/rtl/egsc_cfg_if.sv]
// egsc_cfg_if: register write channel, one register index and data word per beat
// depends on egsc_pkg

interface egsc_cfg_if import egsc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

[hw/rtl/emg_grip_servo_controller.sv]
// emg_grip_servo_controller: envelope filter, grip tracking and servo angle interpolation
// depends on egsc_pkg, egsc_in_if, egsc_out_if, egsc_cfg_if, egsc_mul, egsc_div
//
// Usage:
//   in_ch   takes one envelope sample (unsigned Q8.8) per beat.
//   out_ch  gives one result per sample: servo angle (Q8.8 degrees), grip percent
//           rounded to whole percent, and the filtered envelope truncated to Q8.8.
//   cfg_ch  writes one of eight registers per beat; it is always ready. The user must
//           write only while no sample is in flight; the block does not enforce it.
//           Unknown indexes are dropped.
// Sequencing:
//   a sample is accepted only while the sequencer is idle, and the next one once the
//   result is in the output register, so one sample is worked on at a time. The work
//   is done by one shared bit-serial multiplier (up to three products per sample) and
//   one restoring divider (for the target and the angle). Saturated targets skip the
//   target division, and a grip change below the hold margin or a snap to rest skips
//   the grip product.
// Reset:
//   synchronous rst_n clears the filter and grip state and loads register defaults.
// Stall:
//   the result sits in an output register; a new sample is accepted while it waits,
//   and the sequencer holds its finished result until the output register is free.

module emg_grip_servo_controller import egsc_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)(
  input  logic        clk,
  input  logic        rst_n,
  egsc_in_if.sink     in_ch,
  egsc_out_if.source  out_ch,
  egsc_cfg_if.sink    cfg_ch
);

  localparam int ENV_W  = SAMPLE_WIDTH + 8;
  localparam int MC_W   = (ENV_W > GRIP_W) ? ENV_W : GRIP_W;
  localparam int PROD_W = MC_W + MR_W;
  localparam int RND_W  = MC_W + 2;
  localparam int SUM_W  = MC_W + 4;
  localparam int NUM_W  = ((ENV_W > 24) ? ENV_W : 24) + 1;
  localparam logic [ENV_W-1:0] ENV_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_ENV_START, S_ENV_WAIT, S_ENV_UPD, S_TGT_PRE, S_TGT_CHK, S_TGT_WAIT,
    S_GRIP_PRE, S_GRIP_DLT, S_GRIP_WAIT, S_GRIP_UPD, S_ANG_START, S_ANG_WAIT,
    S_ANG_DIVW, S_OUT
  } state_t;

  // configuration registers
  logic [15:0]       env_open_r, env_close_r, env_alpha_r, grip_alpha_r;
  logic [15:0]       open_angle_r, close_angle_r;
  logic [DEAD_W-1:0] deadband_pct_r;
  logic [HOLD_W-1:0] hold_pct_r;

  // sequencer state and datapath registers
  state_t                   state_r;
  logic [SAMPLE_WIDTH-1:0]  sample_r;
  logic [ENV_W-1:0]         smoothed_r;
  logic [GRIP_W-1:0]        grip_level_r;
  logic [RND_W-1:0]         rnd_r;
  logic                     neg_r;
  logic signed [NUM_W-1:0]  num_r;
  logic [15:0]              span_r;
  logic [GRIP_W-1:0]        tgt_r;
  logic [ANGLE_W-1:0]       aq_r;
  logic                     out_valid_r;
  logic [ANGLE_W-1:0]       servo_angle_r;
  logic [GRIP_PCT_W-1:0]    grip_pct_r;
  logic [FILT_W-1:0]        filtered_level_r;

  // serial unit hookup
  logic                 mul_start;
  logic [MC_W-1:0]      mul_mcand;
  logic [MR_W-1:0]      mul_mplier;
  egsc_unit_sts_t       mul_sts;
  logic [PROD_W-1:0]    mul_product;
  logic                 div_start;
  logic [DIV_W-1:0]     div_rem_init, div_quo_init, div_divisor, div_quotient;
  logic [DIV_CNT_W-1:0] div_steps;
  egsc_unit_sts_t       div_sts;

  // combinational helpers
  logic signed [ENV_W:0]    env_diff;
  logic [ENV_W-1:0]         env_mag;
  logic [PROD_W:0]          rnd_sum;
  logic [MC_W-1:0]          upd_base;
  logic signed [SUM_W-1:0]  upd_sum;
  logic [ENV_W-1:0]         env_nxt;
  logic [GRIP_W-1:0]        grip_nxt;
  logic signed [NUM_W-1:0]  num_nxt;
  logic signed [16:0]       span_diff;
  logic [28:0]              num25;
  logic                     tgt_zero, tgt_full;
  logic [GRIP_W-1:0]        dead;
  logic [GRIP_W-1:0]        hold;
  logic signed [GRIP_W:0]   grip_delta;
  logic [GRIP_W-1:0]        grip_mag;
  logic                     grip_rest, grip_move;
  logic signed [16:0]       ang_diff;
  logic [15:0]              ang_mag;
  logic [DVD_W-1:0]         ang_dvd;
  logic [16:0]              angle_nxt;
  logic [GRIP_W:0]          grip_pct_sum;
  logic [ENV_W+7:0]         smoothed_ext;
  logic                     out_free;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_open_r     <= ENV_OPEN_RST;
      env_close_r    <= ENV_CLOSE_RST;
      env_alpha_r    <= ENV_ALPHA_RST;
      grip_alpha_r   <= GRIP_ALPHA_RST;
      deadband_pct_r <= DEADBAND_PCT_RST;
      hold_pct_r     <= HOLD_PCT_RST;
      open_angle_r   <= OPEN_ANGLE_RST;
      close_angle_r  <= CLOSE_ANGLE_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        REG_ENV_OPEN:     env_open_r     <= cfg_ch.wr_data;
        REG_ENV_CLOSE:    env_close_r    <= cfg_ch.wr_data;
        REG_ENV_ALPHA:    env_alpha_r    <= cfg_ch.wr_data;
        REG_GRIP_ALPHA:   grip_alpha_r   <= cfg_ch.wr_data;
        REG_DEADBAND_PCT: deadband_pct_r <= cfg_ch.wr_data[DEAD_W-1:0];
        REG_HOLD_PCT:     hold_pct_r     <= cfg_ch.wr_data[HOLD_W-1:0];
        REG_OPEN_ANGLE:   open_angle_r   <= cfg_ch.wr_data;
        REG_CLOSE_ANGLE:  close_angle_r  <= cfg_ch.wr_data;
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // envelope error against the sample
  assign env_diff = $signed({1'b0, sample_r, 8'b0}) - $signed({1'b0, smoothed_r});
  assign env_mag  = env_diff[ENV_W] ? ENV_W'(-env_diff) : env_diff[ENV_W-1:0];

  // q15 rounding of the product, half away from zero on the magnitude
  assign rnd_sum = {1'b0, mul_product} + (PROD_W+1)'(ROUND_Q15);

  // signed update and clamps, shared by envelope and grip
  assign upd_base = (state_r == S_ENV_UPD) ? MC_W'(smoothed_r) : MC_W'(grip_level_r);
  assign upd_sum  = neg_r ? ($signed({4'b0, upd_base}) - $signed({2'b0, rnd_r}))
                          : ($signed({4'b0, upd_base}) + $signed({2'b0, rnd_r}));

  always_comb begin
    if (upd_sum < 0) begin
      env_nxt  = '0;
      grip_nxt = '0;
    end else begin
      env_nxt  = (upd_sum > $signed({{(SUM_W-ENV_W){1'b0}}, ENV_MAX}))
                 ? ENV_MAX : upd_sum[ENV_W-1:0];
      grip_nxt = (upd_sum > $signed(SUM_W'(PCT_FULL))) ? PCT_FULL : upd_sum[GRIP_W-1:0];
    end
  end

  // target numerator, span and saturation checks
  assign num_nxt   = $signed(NUM_W'(smoothed_r)) - $signed(NUM_W'({env_open_r, 8'b0}));
  assign span_diff = $signed({1'b0, env_close_r}) - $signed({1'b0, env_open_r});
  assign tgt_zero  = (num_r <= 0);
  assign tgt_full  = (num_r >= $signed(NUM_W'({span_r, 8'b0})));
  assign num25     = (29'(num_r[23:0]) << 4) + (29'(num_r[23:0]) << 3) + 29'(num_r[23:0]);

  // grip delta against deadband and hold margin
  assign dead       = {deadband_pct_r, 8'b0};
  assign hold       = GRIP_W'({hold_pct_r, 8'b0});
  assign grip_delta = $signed({1'b0, tgt_r}) - $signed({1'b0, grip_level_r});
  assign grip_mag   = grip_delta[GRIP_W] ? GRIP_W'(-grip_delta) : grip_delta[GRIP_W-1:0];
  assign grip_rest  = (tgt_r == '0) && (grip_level_r <= dead);
  assign grip_move  = (grip_mag >= hold);

  // angle span and rounded dividend
  assign ang_diff  = $signed({1'b0, close_angle_r}) - $signed({1'b0, open_angle_r});
  assign ang_mag   = ang_diff[16] ? 16'(-ang_diff) : ang_diff[15:0];
  assign ang_dvd   = DVD_W'(mul_product) + ANG_ROUND;
  assign angle_nxt = ang_diff[16] ? ({1'b0, open_angle_r} - {1'b0, aq_r})
                                  : ({1'b0, open_angle_r} + {1'b0, aq_r});

  // result fields
  assign grip_pct_sum = {1'b0, grip_level_r} + PCT_HALF;
  assign smoothed_ext = {8'b0, smoothed_r};
  assign out_free     = !out_valid_r || out_ch.ready;

  // multiplier operand select
  always_comb begin
    mul_start  = 1'b0;
    mul_mcand  = MC_W'(env_mag);
    mul_mplier = env_alpha_r;
    unique case (state_r)
      S_ENV_START: begin
        mul_start = 1'b1;
      end
      S_GRIP_DLT: begin
        mul_start  = !grip_rest && grip_move;
        mul_mcand  = MC_W'(grip_mag);
        mul_mplier = grip_alpha_r;
      end
      S_ANG_START: begin
        mul_start  = 1'b1;
        mul_mcand  = MC_W'(grip_level_r);
        mul_mplier = ang_mag;
      end
      default: ;
    endcase
  end

  // divider operand select
  always_comb begin
    div_start    = 1'b0;
    div_rem_init = DIV_W'(num25[28:13]);
    div_quo_init = {num25[12:0], 10'b0};
    div_divisor  = DIV_W'(span_r);
    div_steps    = TGT_DIV_STEPS;
    unique case (state_r)
      S_TGT_CHK: begin
        div_start = !tgt_zero && !tgt_full;
      end
      S_ANG_WAIT: begin
        div_start    = mul_sts.done;
        div_rem_init = ang_dvd[DVD_W-1:16];
        div_quo_init = {ang_dvd[15:0], 7'b0};
        div_divisor  = PCT_FULL;
        div_steps    = ANG_DIV_STEPS;
      end
      default: ;
    endcase
  end

  egsc_mul #(.MC_W(MC_W)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .sts     (mul_sts),
    .product (mul_product)
  );

  egsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem_init),
    .quo_init (div_quo_init),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .sts      (div_sts),
    .quotient (div_quotient)
  );

  // sequencer, filter and grip state, output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      smoothed_r   <= '0;
      grip_level_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // the output step reloads the register itself
      if (out_valid_r && out_ch.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            sample_r <= in_ch.envelope_sample;
            state_r  <= S_ENV_START;
          end
        end
        S_ENV_START: begin
          neg_r   <= env_diff[ENV_W];
          state_r <= S_ENV_WAIT;
        end
        S_ENV_WAIT: begin
          if (mul_sts.done) begin
            rnd_r   <= rnd_sum[PROD_W:15];
            state_r <= S_ENV_UPD;
          end
        end
        S_ENV_UPD: begin
          smoothed_r <= env_nxt;
          state_r    <= S_TGT_PRE;
        end
        S_TGT_PRE: begin
          num_r   <= num_nxt;
          span_r  <= (span_diff < $signed({1'b0, SPAN_FLOOR})) ? SPAN_FLOOR : span_diff[15:0];
          state_r <= S_TGT_CHK;
        end
        S_TGT_CHK: begin
          if (tgt_zero) begin
            tgt_r   <= '0;
            state_r <= S_GRIP_PRE;
          end else if (tgt_full) begin
            tgt_r   <= PCT_FULL;
            state_r <= S_GRIP_PRE;
          end else begin
            state_r <= S_TGT_WAIT;
          end
        end
        S_TGT_WAIT: begin
          if (div_sts.done) begin
            tgt_r   <= div_quotient;
            state_r <= S_GRIP_PRE;
          end
        end
        S_GRIP_PRE: begin
          if (tgt_r < dead) begin
            tgt_r <= '0;
          end
          state_r <= S_GRIP_DLT;
        end
        S_GRIP_DLT: begin
          neg_r <= grip_delta[GRIP_W];
          if (grip_rest) begin
            grip_level_r <= '0;
            state_r      <= S_ANG_START;
          end else if (grip_move) begin
            state_r <= S_GRIP_WAIT;
          end else begin
            state_r <= S_ANG_START;
          end
        end
        S_GRIP_WAIT: begin
          if (mul_sts.done) begin
            rnd_r   <= rnd_sum[PROD_W:15];
            state_r <= S_GRIP_UPD;
          end
        end
        S_GRIP_UPD: begin
          grip_level_r <= grip_nxt;
          state_r      <= S_ANG_START;
        end
        S_ANG_START: begin
          state_r <= S_ANG_WAIT;
        end
        S_ANG_WAIT: begin
          if (mul_sts.done) begin
            state_r <= S_ANG_DIVW;
          end
        end
        S_ANG_DIVW: begin
          if (div_sts.done) begin
            aq_r    <= div_quotient[ANGLE_W-1:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r      <= 1'b1;
            servo_angle_r    <= angle_nxt[ANGLE_W-1:0];
            grip_pct_r       <= grip_pct_sum[GRIP_W-1:16];
            filtered_level_r <= smoothed_ext[FILT_W+7:8];
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.servo_angle    = servo_angle_r;
  assign out_ch.grip_pct       = grip_pct_r;
  assign out_ch.filtered_level = filtered_level_r;

  // grip level never leaves 0..100 percent
  assert property (@(posedge clk) disable iff (!rst_n) grip_level_r <= PCT_FULL)
    else $error("grip level above full scale");

  // multiplier is never restarted while a product is in progress
  assert property (@(posedge clk) disable iff (!rst_n) mul_start |-> !mul_sts.busy)
    else $error("multiplier started while busy");

  // divider is never restarted while a quotient is in progress
  assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_sts.busy)
    else $error("divider started while busy");

  // a new result beat only comes out of the final sequencer step
  assert property (@(posedge clk) disable iff (!rst_n)
                   $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside output step");

endmodule

[hw/rtl/egsc_mul.sv]
// egsc_mul: bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on egsc_pkg

module egsc_mul import egsc_pkg::*; #(
  parameter int MC_W = GRIP_W
)(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [MC_W-1:0]        mcand,
  input  logic [MR_W-1:0]        mplier,
  output egsc_unit_sts_t         sts,
  output logic [MC_W+MR_W-1:0]   product
);

  logic [MC_W-1:0]      mc_r;
  logic [MC_W-1:0]      acc_r;
  logic [MR_W-1:0]      mr_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [MC_W:0]        sum_nxt;

  // partial product add for the current multiplier bit
  assign sum_nxt = {1'b0, acc_r} + (mr_r[0] ? {1'b0, mc_r} : '0);

  // control: step counter, busy and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= MUL_CNT_W'(MR_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: accumulator and multiplier shift right together
  always_ff @(posedge clk) begin
    if (start) begin
      mc_r  <= mcand;
      mr_r  <= mplier;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= sum_nxt[MC_W:1];
      mr_r  <= {sum_nxt[0], mr_r[MR_W-1:1]};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign product  = {acc_r, mr_r};

endmodule

[hw/rtl/egsc_div.sv]
// egsc_div: bit-serial restoring divider, one quotient bit per cycle
// depends on egsc_pkg; caller preloads the high part of the dividend as remainder

module egsc_div import egsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_W-1:0]     rem_init,
  input  logic [DIV_W-1:0]     quo_init,
  input  logic [DIV_W-1:0]     divisor,
  input  logic [DIV_CNT_W-1:0] steps,
  output egsc_unit_sts_t       sts,
  output logic [DIV_W-1:0]     quotient
);

  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DIV_W-1:0]     dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_W+1:0]     trial_nxt;

  // trial subtract of the divisor from the shifted remainder
  assign trial_nxt = {1'b0, rem_r, quo_r[DIV_W-1]} - {2'b00, dsr_r};

  // control: step counter, busy and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps - 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: restore on borrow, shift quotient bit in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      quo_r <= quo_init;
      dsr_r <= divisor;
    end else if (busy_r) begin
      if (!trial_nxt[DIV_W+1]) begin
        rem_r <= trial_nxt[DIV_W-1:0];
      end else begin
        rem_r <= {rem_r[DIV_W-2:0], quo_r[DIV_W-1]};
      end
      quo_r <= {quo_r[DIV_W-2:0], ~trial_nxt[DIV_W+1]};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule
